### hdl/ctbd_pkg.sv
// ----------------------------------------------------------------------------
// Capacitive touch baseline detector package
// Shared widths, codes, reset values, types and channel sequencing functions.
// ----------------------------------------------------------------------------
package ctbd_pkg;

	// Default values of the top-level parameters.
	localparam int CHANNELS_DEF       = 16;
	localparam int HISTORY_WEIGHT_DEF = 8;

	// Field widths.
	localparam int CHAN_W     = 4;
	localparam int CHAN_NUM   = 1 << CHAN_W;
	localparam int COUNT_W    = 16;
	localparam int LEVEL_W    = 8;
	localparam int REG_W      = 8;
	localparam int ACTION_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int GAIN_SHIFT = 5;

	// Action codes.
	localparam logic [ACTION_W-1:0] ACT_MEASURE   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_CALIBRATE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_ADVANCE   = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 2'd1;

	// Reset values.
	localparam logic [REG_W-1:0]   THRESHOLD_RESET = 8'd80;
	localparam logic [REG_W-1:0]   GAIN_RESET      = 8'd32;
	localparam logic [COUNT_W-1:0] BASELINE_RESET  = 16'hFFFF;

	// Configuration register contents.
	typedef struct packed {
		logic [REG_W-1:0] threshold;
		logic [REG_W-1:0] gain;
	} cfg_t;

	// One input transaction held in the input register.
	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [COUNT_W-1:0]  raw_count;
	} item_t;

	// Reflected Gray code of a step count.
	function automatic logic [CHAN_W-1:0] gray_code(input logic [CHAN_W-1:0] k);
		return k ^ (k >> 1);
	endfunction

	// Next step count whose Gray code is a channel below the channel count.
	function automatic logic [CHAN_W-1:0] gray_advance(input logic [CHAN_W-1:0] k,
			input logic [CHAN_W:0] channels);
		logic [CHAN_W-1:0] cand;
		logic [CHAN_W-1:0] pick;
		logic              found;
		pick  = k;
		found = 1'b0;
		for (int j = 1; j <= CHAN_NUM; j++) begin
			cand = k + CHAN_W'(j);
			if (!found && ({1'b0, gray_code(cand)} < channels)) begin
				pick  = cand;
				found = 1'b1;
			end
		end
		return pick;
	endfunction

endpackage

### hdl/ctbd_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the touch threshold and the level gain, written by index.
// ----------------------------------------------------------------------------
module ctbd_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [ctbd_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [ctbd_pkg::REG_W-1:0]       wr_data,
	output ctbd_pkg::cfg_t                   cfg
);

	ctbd_pkg::cfg_t cfg_q;

	// Register writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= ctbd_pkg::THRESHOLD_RESET;
			cfg_q.gain      <= ctbd_pkg::GAIN_RESET;
		end else if (wr_en) begin
			case (wr_index)
				ctbd_pkg::REG_THRESHOLD: cfg_q.threshold <= wr_data;
				ctbd_pkg::REG_GAIN:      cfg_q.gain      <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hdl/ctbd_chan_seq.sv
// ----------------------------------------------------------------------------
// Channel sequencer
// Steps the multiplexer channel through the reflected Gray sequence,
// skipping codes at or above the channel count.
// ----------------------------------------------------------------------------
module ctbd_chan_seq #(
	parameter int CHANNELS = ctbd_pkg::CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          advance,
	output logic [ctbd_pkg::CHAN_W-1:0]   chan_cur,
	output logic [ctbd_pkg::CHAN_W-1:0]   chan_next
);

	logic [ctbd_pkg::CHAN_W-1:0] step_q;
	logic [ctbd_pkg::CHAN_W-1:0] step_nxt;

	// All four bits of the step count are the Gray step counter.
	assign step_nxt  = ctbd_pkg::gray_advance(step_q, (ctbd_pkg::CHAN_W + 1)'(CHANNELS));
	assign chan_cur  = ctbd_pkg::gray_code(step_q);
	assign chan_next = advance ? ctbd_pkg::gray_code(step_nxt) : chan_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (step && advance) begin
			step_q <= step_nxt;
		end
	end

endmodule

### hdl/ctbd_baseline_unit.sv
// ----------------------------------------------------------------------------
// Baseline unit
// Per-channel baseline registers, level computation, touch decision and
// the weighted baseline update.
// ----------------------------------------------------------------------------
module ctbd_baseline_unit #(
	parameter int CHANNELS       = ctbd_pkg::CHANNELS_DEF,
	parameter int HISTORY_WEIGHT = ctbd_pkg::HISTORY_WEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  ctbd_pkg::item_t                item,
	input  logic [ctbd_pkg::CHAN_W-1:0]    chan,
	input  ctbd_pkg::cfg_t                 cfg,
	output logic                           touched,
	output logic [ctbd_pkg::LEVEL_W-1:0]   level
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CW   = ctbd_pkg::COUNT_W;
	localparam int PL_W = CW + ctbd_pkg::REG_W;
	localparam int SC_W = PL_W - ctbd_pkg::GAIN_SHIFT;

	// Exact reciprocal for division by HISTORY_WEIGHT + 1 of a value below 2^DIV_N.
	localparam int DIV_D  = HISTORY_WEIGHT + 1;
	localparam int DIV_L  = $clog2(DIV_D);
	localparam int DIV_N  = CW + 1;
	localparam int DIV_S  = DIV_N + DIV_L;
	localparam int DIV_MW = DIV_N + 2;
	localparam int PROD_W = DIV_S + CW;
	localparam longint unsigned DIV_M =
		((64'd1 << DIV_S) + 64'(DIV_D) - 64'd1) / 64'(DIV_D);
	localparam logic [DIV_MW-1:0] DIV_RECIP = DIV_MW'(DIV_M);

	logic [CW-1:0]                  base_q [CHANNELS];
	logic [CW-1:0]                  base;
	logic [CW-1:0]                  raw;
	logic                           raw_ge;
	logic [CW-1:0]                  mag;
	logic [PL_W-1:0]                lvl_prod;
	logic [SC_W-1:0]                lvl_scaled;
	logic [ctbd_pkg::LEVEL_W-1:0]   lvl_sample;
	logic                           hit;
	logic [DIV_N-1:0]               div_num;
	logic [PROD_W-1:0]              div_prod;
	logic [CW-1:0]                  div_q;
	logic [CW-1:0]                  base_new;
	logic                           base_we;
	logic [CH_W-1:0]                idx;

	assign idx  = chan[CH_W-1:0];
	assign base = base_q[idx];
	assign raw  = item.raw_count;

	// Magnitude of the difference between count and baseline.
	assign raw_ge = (raw >= base);
	assign mag    = raw_ge ? (raw - base) : (base - raw);

	// Level: gain times the positive difference over 32, clamped to 255.
	assign lvl_prod   = PL_W'(mag) * PL_W'(cfg.gain);
	assign lvl_scaled = lvl_prod[PL_W-1:ctbd_pkg::GAIN_SHIFT];
	always_comb begin
		if (!raw_ge || (mag == '0)) begin
			lvl_sample = '0;
		end else if (|lvl_scaled[SC_W-1:ctbd_pkg::LEVEL_W]) begin
			lvl_sample = '1;
		end else begin
			lvl_sample = lvl_scaled[ctbd_pkg::LEVEL_W-1:0];
		end
	end
	assign hit = (lvl_sample > cfg.threshold);

	// The weighted mean equals the baseline moved by the difference over the
	// weight plus one, rounded down when rising and up when falling.
	assign div_num  = raw_ge ? DIV_N'(mag) : (DIV_N'(mag) + DIV_N'(DIV_D - 1));
	assign div_prod = PROD_W'(div_num) * PROD_W'(DIV_RECIP);
	assign div_q    = div_prod[DIV_S +: CW];
	assign base_new = raw_ge ? (base + div_q) : (base - div_q);

	// Result fields and baseline write enable per action.
	always_comb begin
		touched = 1'b0;
		level   = '0;
		base_we = 1'b0;
		case (item.action)
			ctbd_pkg::ACT_MEASURE: begin
				touched = hit;
				level   = lvl_sample;
				base_we = !hit;
			end
			ctbd_pkg::ACT_CALIBRATE: begin
				level   = lvl_sample;
				base_we = 1'b1;
			end
			default: ;
		endcase
	end

	// Baseline registers, all at full scale after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				base_q[i] <= ctbd_pkg::BASELINE_RESET;
			end
		end else if (step && base_we) begin
			base_q[idx] <= base_new;
		end
	end

endmodule

### hdl/capacitive_touch_baseline_detector.sv
// ----------------------------------------------------------------------------
// Capacitive touch baseline detector
// Capacitive touch baseline detector. Each input transaction carries one raw
// count for the currently selected channel and an action (measure, calibrate
// and advance, or advance only); each one yields exactly one result with the
// touch flag, the clamped level and the channel select after the action. A
// transaction enters the input register, and once the result register is free the
// level, touch decision, baseline update and channel step are done in one
// pass that loads the result register, so one transaction is taken every
// clock cycle while out_ready stays high. Throughput is set by the
// read-modify-write of the baseline register of the current channel. The
// input side keeps accepting while a result waits, and stalls only when
// both the input and result registers are full. Baselines come out of
// reset at full scale; no clearing pass is needed.
// Configuration writes are always accepted and should be issued while idle.
// ----------------------------------------------------------------------------
module capacitive_touch_baseline_detector #(
	parameter int CHANNELS       = ctbd_pkg::CHANNELS_DEF,
	parameter int HISTORY_WEIGHT = ctbd_pkg::HISTORY_WEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ctbd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ctbd_pkg::REG_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [ctbd_pkg::ACTION_W-1:0]    action,
	input  logic [ctbd_pkg::COUNT_W-1:0]     raw_count,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             touched,
	output logic [ctbd_pkg::LEVEL_W-1:0]     level,
	output logic [ctbd_pkg::CHAN_W-1:0]      channel
);

	ctbd_pkg::cfg_t                 cfg;
	ctbd_pkg::item_t                item_s1;
	logic                           valid_s1;
	logic                           fire_s1;
	logic                           in_fire;
	logic                           advance;
	logic [ctbd_pkg::CHAN_W-1:0]    chan_cur;
	logic [ctbd_pkg::CHAN_W-1:0]    chan_next;
	logic                           hit;
	logic [ctbd_pkg::LEVEL_W-1:0]   lvl;
	logic                           out_valid_q;
	logic                           touched_q;
	logic [ctbd_pkg::LEVEL_W-1:0]   level_q;
	logic [ctbd_pkg::CHAN_W-1:0]    channel_q;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	ctbd_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Handshake: the input register moves on when the result register is free.
	assign fire_s1  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire_s1;
	assign in_fire  = in_valid && in_ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.action    <= action;
			item_s1.raw_count <= raw_count;
		end
	end

	assign advance = (item_s1.action == ctbd_pkg::ACT_CALIBRATE) ||
		(item_s1.action == ctbd_pkg::ACT_ADVANCE);

	// Channel sequencer.
	ctbd_chan_seq #(
		.CHANNELS (CHANNELS)
	) u_chan_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (fire_s1),
		.advance   (advance),
		.chan_cur  (chan_cur),
		.chan_next (chan_next)
	);

	// Baseline tracking and level computation.
	ctbd_baseline_unit #(
		.CHANNELS       (CHANNELS),
		.HISTORY_WEIGHT (HISTORY_WEIGHT)
	) u_baseline_unit (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (fire_s1),
		.item    (item_s1),
		.chan    (chan_cur),
		.cfg     (cfg),
		.touched (hit),
		.level   (lvl)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			touched_q <= hit;
			level_q   <= lvl;
			channel_q <= chan_next;
		end
	end

	assign out_valid = out_valid_q;
	assign touched   = touched_q;
	assign level     = level_q;
	assign channel   = channel_q;

`ifndef NO_ASSERTIONS
	// A transaction leaving the input register always lands in the result register.
	a_fire_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |=> out_valid_q)
		else $error("result register not loaded after input register moved");

	// An accepted transaction is held in the input register next cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> valid_s1)
		else $error("accepted transaction missing from input register");

	// A full, stalled input register blocks new transactions.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ready) |-> !in_ready)
		else $error("input accepted while pipeline is stalled");

	// A touch always comes with a nonzero level.
	a_touch_has_level: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && touched_q) |-> (level_q != '0))
		else $error("touch reported with zero level");

	// The reported channel is always within the channel count.
	a_channel_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ({1'b0, channel_q} < (ctbd_pkg::CHAN_W + 1)'(CHANNELS)))
		else $error("channel select out of range");
`endif

endmodule
